@@ src/rau_pkg.sv @@
// ============================================================================
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand and result widths, operation codes, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RESULT_WIDTH  = 34;
    localparam int CMD_WIDTH     = 3;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int RAW_WIDTH     = 2 * OPERAND_WIDTH + 2;
    localparam int SHIFT_WIDTH   = $clog2(RAW_WIDTH + 1);
    localparam int CNT_WIDTH     = $clog2(RAW_WIDTH);

    typedef enum logic [CMD_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5
    } rau_op_t;

    typedef enum logic [1:0] {
        MP_AN_BD,
        MP_AN_BN,
        MP_AD_BN,
        MP_AD_BD
    } rau_mul_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_N_PROD,
        WB_N_ADD,
        WB_N_SUB,
        WB_D_PROD,
        WB_INC,
        WB_DEC,
        WB_PASS
    } rau_wb_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_GCD_INIT,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } rau_state_t;

    typedef struct packed {
        logic     load;
        rau_mul_t mul_sel;
        rau_wb_t  wb;
        logic     gcd_init;
        logic     gcd_step;
        logic     gcd_finish;
        logic     div_step;
        logic     out_load;
    } rau_cmd_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] op;
        logic                 gcd_done;
        logic                 div_last;
    } rau_status_t;

endpackage

@@ src/rational_arithmetic_unit_top.sv @@
// ============================================================================
// rational_arithmetic_unit_top: fraction arithmetic with gcd reduction
// From input transfer to result valid the unit runs four product steps, gcd
// setup, the binary gcd steps and a finish step, 34 steps of the shared
// two-lane restoring divider and the output load. One item is processed at a
// time; the next input is taken once the result sits in the output register,
// even while that result waits for a transfer.
// Synchronous active-low reset clears the controller state and result valid.
// ============================================================================
module rational_arithmetic_unit_top (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [rau_pkg::CMD_WIDTH-1:0]            s_command,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_den,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [rau_pkg::RESULT_WIDTH-1:0]  m_result_num,
    output logic signed [rau_pkg::RESULT_WIDTH-1:0]  m_result_den,
    output logic                                     m_status
);

    rau_pkg::rau_cmd_t    ctl;
    rau_pkg::rau_status_t sts;

    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    rau_datapath u_datapath (
        .aclk         (aclk),
        .ctl          (ctl),
        .sts          (sts),
        .s_command    (s_command),
        .s_a_num      (s_a_num),
        .s_a_den      (s_a_den),
        .s_b_num      (s_b_num),
        .s_b_den      (s_b_den),
        .m_result_num (m_result_num),
        .m_result_den (m_result_den),
        .m_status     (m_status)
    );

endmodule

@@ src/rau_datapath.sv @@
// ============================================================================
// rau_datapath: operand registers, shared multiplier, gcd and divider
// Holds the captured operands, forms the raw fraction with one shared
// multiplier, reduces it with a binary gcd and a two-lane restoring divider
// that shares the gcd as divisor, and holds the result payload.
// ============================================================================
module rau_datapath (
    input  logic                                     aclk,
    input  rau_pkg::rau_cmd_t                        ctl,
    output rau_pkg::rau_status_t                     sts,
    input  logic [rau_pkg::CMD_WIDTH-1:0]            s_command,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_den,
    output logic signed [rau_pkg::RESULT_WIDTH-1:0]  m_result_num,
    output logic signed [rau_pkg::RESULT_WIDTH-1:0]  m_result_den,
    output logic                                     m_status
);

    localparam int OW  = rau_pkg::OPERAND_WIDTH;
    localparam int RW  = rau_pkg::RAW_WIDTH;
    localparam int PW  = rau_pkg::PROD_WIDTH;

    function automatic logic [RW-1:0] mag(input logic signed [RW-1:0] x);
        mag = x[RW-1] ? RW'(-x) : RW'(x);
    endfunction

    logic [rau_pkg::CMD_WIDTH-1:0]   op_reg;
    logic signed [OW-1:0]            an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [OW-1:0]            mul_x, mul_y;
    logic signed [PW-1:0]            prod_next, prod_reg;
    logic signed [RW-1:0]            n_reg, d_reg;
    logic [RW-1:0]                   u_reg, v_reg, g_reg;
    logic [RW-1:0]                   diff_uv, diff_vu;
    logic [rau_pkg::SHIFT_WIDTH-1:0] k_reg;
    logic                            undef_reg, n_neg_reg, d_neg_reg;
    logic [rau_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [RW-1:0]                   rem_reg [2];
    logic [RW-1:0]                   quo_reg [2];
    logic [RW-1:0]                   rem_next [2];
    logic [RW-1:0]                   quo_next [2];
    logic [RW:0]                     shifted [2];
    logic [RW:0]                     trial [2];
    logic signed [RW-1:0]            num_signed, den_signed;
    logic signed [RW-1:0]            prod_ext;

    always_comb begin
        case (ctl.mul_sel)
            rau_pkg::MP_AN_BD: begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
            rau_pkg::MP_AN_BN: begin
                mul_x = an_reg;
                mul_y = bn_reg;
            end
            rau_pkg::MP_AD_BN: begin
                mul_x = ad_reg;
                mul_y = bn_reg;
            end
            default: begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign prod_next = mul_x * mul_y;
    assign prod_ext  = RW'(prod_reg);
    assign diff_uv   = u_reg - v_reg;
    assign diff_vu   = v_reg - u_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            shifted[i]  = {rem_reg[i], quo_reg[i][RW-1]};
            trial[i]    = shifted[i] - {1'b0, g_reg};
            if (shifted[i] >= {1'b0, g_reg}) begin
                rem_next[i] = trial[i][RW-1:0];
                quo_next[i] = {quo_reg[i][RW-2:0], 1'b1};
            end else begin
                rem_next[i] = shifted[i][RW-1:0];
                quo_next[i] = {quo_reg[i][RW-2:0], 1'b0};
            end
        end
    end

    assign num_signed = n_neg_reg ? -$signed(quo_reg[0]) : $signed(quo_reg[0]);
    assign den_signed = d_neg_reg ? -$signed(quo_reg[1]) : $signed(quo_reg[1]);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            op_reg <= s_command;
            an_reg <= s_a_num;
            ad_reg <= s_a_den;
            bn_reg <= s_b_num;
            bd_reg <= s_b_den;
        end

        prod_reg <= prod_next;

        case (ctl.wb)
            rau_pkg::WB_N_PROD: n_reg <= prod_ext;
            rau_pkg::WB_N_ADD:  n_reg <= n_reg + prod_ext;
            rau_pkg::WB_N_SUB:  n_reg <= n_reg - prod_ext;
            rau_pkg::WB_D_PROD: d_reg <= prod_ext;
            rau_pkg::WB_INC: begin
                n_reg <= RW'(an_reg) + RW'(ad_reg);
                d_reg <= RW'(ad_reg);
            end
            rau_pkg::WB_DEC: begin
                n_reg <= RW'(an_reg) - RW'(ad_reg);
                d_reg <= RW'(ad_reg);
            end
            rau_pkg::WB_PASS: begin
                n_reg <= RW'(an_reg);
                d_reg <= RW'(ad_reg);
            end
            default: begin
            end
        endcase

        if (ctl.gcd_init) begin
            u_reg <= mag(n_reg);
            v_reg <= mag(d_reg);
            k_reg <= '0;
        end else if (ctl.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg > v_reg) begin
                u_reg <= diff_uv >> 1;
            end else begin
                v_reg <= diff_vu >> 1;
            end
        end

        if (ctl.gcd_finish) begin
            g_reg      <= ((u_reg == '0) ? v_reg : u_reg) << k_reg;
            undef_reg  <= (u_reg == '0) && (v_reg == '0);
            n_neg_reg  <= n_reg[RW-1];
            d_neg_reg  <= d_reg[RW-1];
            quo_reg[0] <= mag(n_reg);
            quo_reg[1] <= mag(d_reg);
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            cnt_reg    <= '0;
        end else if (ctl.div_step) begin
            quo_reg[0] <= quo_next[0];
            quo_reg[1] <= quo_next[1];
            rem_reg[0] <= rem_next[0];
            rem_reg[1] <= rem_next[1];
            cnt_reg    <= cnt_reg + 1'b1;
        end

        if (ctl.out_load) begin
            m_result_num <= undef_reg ? '0 : rau_pkg::RESULT_WIDTH'(num_signed);
            m_result_den <= undef_reg ? '0 : rau_pkg::RESULT_WIDTH'(den_signed);
            m_status     <= undef_reg;
        end
    end

    assign sts.op       = op_reg;
    assign sts.gcd_done = (u_reg == '0) || (v_reg == '0) || (u_reg == v_reg);
    assign sts.div_last = (cnt_reg == rau_pkg::CNT_WIDTH'(RW - 1));

endmodule

@@ src/rau_ctrl.sv @@
// ============================================================================
// rau_ctrl: sequencing controller of the rational arithmetic unit
// Steps the datapath through operand capture, products, gcd reduction and
// division, and owns the handshake flags of both channels.
// ============================================================================
module rau_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rau_pkg::rau_status_t sts,
    output rau_pkg::rau_cmd_t    ctl
);

    rau_pkg::rau_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ctl.load       = 1'b0;
        ctl.mul_sel    = rau_pkg::MP_AN_BD;
        ctl.wb         = rau_pkg::WB_NONE;
        ctl.gcd_init   = 1'b0;
        ctl.gcd_step   = 1'b0;
        ctl.gcd_finish = 1'b0;
        ctl.div_step   = 1'b0;
        ctl.out_load   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = rau_pkg::ST_MUL0;
                end
            end
            rau_pkg::ST_MUL0: begin
                case (sts.op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_DIV: begin
                        ctl.mul_sel = rau_pkg::MP_AN_BD;
                    end
                    rau_pkg::OP_MUL: ctl.mul_sel = rau_pkg::MP_AN_BN;
                    rau_pkg::OP_INC: ctl.wb = rau_pkg::WB_INC;
                    rau_pkg::OP_DEC: ctl.wb = rau_pkg::WB_DEC;
                    default:         ctl.wb = rau_pkg::WB_PASS;
                endcase
                state_next = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                case (sts.op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_DIV: begin
                        ctl.wb      = rau_pkg::WB_N_PROD;
                        ctl.mul_sel = rau_pkg::MP_AD_BN;
                    end
                    rau_pkg::OP_MUL: begin
                        ctl.wb      = rau_pkg::WB_N_PROD;
                        ctl.mul_sel = rau_pkg::MP_AD_BD;
                    end
                    default: begin
                    end
                endcase
                state_next = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                ctl.mul_sel = rau_pkg::MP_AD_BD;
                case (sts.op)
                    rau_pkg::OP_ADD: ctl.wb = rau_pkg::WB_N_ADD;
                    rau_pkg::OP_SUB: ctl.wb = rau_pkg::WB_N_SUB;
                    rau_pkg::OP_MUL, rau_pkg::OP_DIV: ctl.wb = rau_pkg::WB_D_PROD;
                    default: begin
                    end
                endcase
                state_next = rau_pkg::ST_MUL3;
            end
            rau_pkg::ST_MUL3: begin
                case (sts.op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: ctl.wb = rau_pkg::WB_D_PROD;
                    default: begin
                    end
                endcase
                state_next = rau_pkg::ST_GCD_INIT;
            end
            rau_pkg::ST_GCD_INIT: begin
                ctl.gcd_init = 1'b1;
                state_next   = rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD: begin
                if (sts.gcd_done) begin
                    ctl.gcd_finish = 1'b1;
                    state_next     = rau_pkg::ST_DIV;
                end else begin
                    ctl.gcd_step = 1'b1;
                end
            end
            rau_pkg::ST_DIV: begin
                ctl.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = rau_pkg::ST_DONE;
                end
            end
            rau_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == rau_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    // A new result never overwrites one that has not been transferred.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    // An accepted input starts the product sequence on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == rau_pkg::ST_MUL0))
        else $error("accepted input did not start the product sequence");

    // The last divider step hands over to the output stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rau_pkg::ST_DIV && sts.div_last) |=>
            (state_reg == rau_pkg::ST_DONE))
        else $error("divider did not finish after its last step");

    // A result is loaded only in the output stage and always leaves valid set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |=> (m_valid && $past(state_reg == rau_pkg::ST_DONE)))
        else $error("result load outside the output stage");

endmodule
